### sv/hvf_pkg.sv
`timescale 1ns / 1ps

package hvf_pkg;

    localparam int SAMPLE_BITS = 12;

    localparam int ADC_W    = 12;
    localparam int ACC_W    = 28;
    localparam int VOLT_W   = 11;
    localparam int TARGET_W = 10;
    localparam int SCALE_W  = 15;
    localparam int PROD_W   = 27;

    localparam logic [ADC_W-1:0] SAMPLE_MASK =
        ADC_W'((64'd1 << SAMPLE_BITS) - 64'd1) & ADC_W'(12'hFFF);

    localparam int ACC_SHIFT_IN   = 6;
    localparam int ACC_LEAK_SHIFT = 10;
    localparam int ACC_TOP_SHIFT  = 16;

    localparam logic [SCALE_W-1:0]  SCALE_MUL    = SCALE_W'(19600);
    localparam logic [TARGET_W-1:0] TARGET_MAX   = TARGET_W'(950);
    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(900);
    localparam logic [TARGET_W-1:0] BAND         = TARGET_W'(5);

    localparam logic [ACC_W-1:0] ACC_LIMIT = ACC_W'(4095 * 65536);

    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] acc;
    } hvf_stage_t;

endpackage

### sv/hvf_integrator.sv
`timescale 1ns / 1ps

module hvf_integrator
    import hvf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ADC_W-1:0] adc_sample,
    input  logic             stage_ready,
    output hvf_stage_t       stage
);

    logic             stage_valid_reg;
    logic             stage_valid_next;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ADC_W-1:0] sample;
    logic             accept;
    logic             handoff;

    assign sample   = adc_sample & SAMPLE_MASK;
    assign handoff  = stage_valid_reg && stage_ready;
    assign in_stall = stage_valid_reg && !stage_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        acc_next = acc_reg + (ACC_W'(sample) << ACC_SHIFT_IN) - (acc_reg >> ACC_LEAK_SHIFT);
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (handoff)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            acc_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign stage.valid = stage_valid_reg;
    assign stage.acc   = acc_reg;

    // The leaky integrator settles at sample << 16 and can never climb past full scale.
    assert property (@(posedge clk) disable iff (!rst_n) acc_reg <= ACC_LIMIT)
        else $error("filter accumulator above full scale");

    // A new word is only taken while the stage register is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!stage_valid_reg || stage_ready))
        else $error("stage register overwritten");

endmodule

### sv/hvf_regulator.sv
`timescale 1ns / 1ps

module hvf_regulator
    import hvf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                target_write,
    input  logic [TARGET_W-1:0] target_data,
    input  hvf_stage_t          stage,
    output logic                stage_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VOLT_W-1:0]   measured_voltage,
    output logic                charge_enable
);

    logic [TARGET_W-1:0] target_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VOLT_W-1:0]   volts_reg;
    logic                enable_reg;
    logic                enable_next;
    logic [PROD_W-1:0]   product;
    logic [VOLT_W-1:0]   volts;
    logic                low_hit;
    logic                high_hit;
    logic                load;

    assign stage_ready = !out_valid_reg || !out_stall;
    assign load        = stage.valid && stage_ready;

    always_comb
    begin
        product  = PROD_W'(stage.acc[ACC_W-1:ACC_TOP_SHIFT]) * PROD_W'(SCALE_MUL);
        volts    = product[PROD_W-1:ACC_TOP_SHIFT];
        low_hit  = (target_reg >= BAND)
                   && ({1'b0, volts} < {2'b00, target_reg - BAND});
        high_hit = {1'b0, volts} > ({2'b00, target_reg} + {2'b00, BAND});
        priority if (low_hit)
        begin
            enable_next = 1'b1;
        end
        else if (high_hit)
        begin
            enable_next = 1'b0;
        end
        else
        begin
            enable_next = enable_reg;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b0;
        end
        else
        begin
            if (target_write)
            begin
                target_reg <= (target_data > TARGET_MAX) ? TARGET_MAX : target_data;
            end
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                enable_reg <= enable_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            volts_reg <= volts;
        end
    end

    assign out_valid        = out_valid_reg;
    assign measured_voltage = volts_reg;
    assign charge_enable    = enable_reg;

    assert property (@(posedge clk) disable iff (!rst_n) target_reg <= TARGET_MAX)
        else $error("set point above its limit");

    assert property (@(posedge clk) disable iff (!rst_n) load && low_hit |=> enable_reg)
        else $error("enable not switched on below the band");

    assert property (@(posedge clk) disable iff (!rst_n)
        load && !low_hit && high_hit |=> !enable_reg)
        else $error("enable not switched off above the band");

    assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> enable_reg == $past(enable_reg))
        else $error("enable changed without a new word");

endmodule

### sv/hv_filter_hysteresis_regulator_core.sv
`timescale 1ns / 1ps

// High-voltage filter and hysteresis regulator.
// The input channel (in_valid, in_stall, adc_sample) carries one converter
// sample per word; the output channel (out_valid, out_stall, measured_voltage,
// charge_enable) returns one word per sample, in order.
// Each accepted sample updates a leaky-integrator accumulator; the filtered
// reading is scaled to volts and compared with the set point, switching the
// charge enable on below the lower band edge and off above the upper one.
// The set point is written through target_write and target_data; the user
// must do so only while the block is idle, which the block does not enforce;
// values above 950 are clamped to 950. Each sample passes through the
// accumulator update into the stage register, then the scaling multiply and
// threshold compare into the output register. A new sample is taken every
// cycle while in_stall is low.
// Reset clears the accumulator, drops the charge enable, empties both
// stages and loads a set point of 900 V.
// While the receiver stalls, the output word is held; one further sample can
// still be accepted into the accumulator stage before in_stall is raised.

module hv_filter_hysteresis_regulator_core
    import hvf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ADC_W-1:0]    adc_sample,
    input  logic                target_write,
    input  logic [TARGET_W-1:0] target_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VOLT_W-1:0]   measured_voltage,
    output logic                charge_enable
);

    hvf_stage_t stage;
    logic       stage_ready;

    hvf_integrator u_integrator (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .adc_sample  (adc_sample),
        .stage_ready (stage_ready),
        .stage       (stage)
    );

    hvf_regulator u_regulator (
        .clk              (clk),
        .rst_n            (rst_n),
        .target_write     (target_write),
        .target_data      (target_data),
        .stage            (stage),
        .stage_ready      (stage_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .measured_voltage (measured_voltage),
        .charge_enable    (charge_enable)
    );

endmodule
